// File: hw/rtl/stwl_pkg.sv
// Shared types and constants of the stopwatch lap timer.
`default_nettype none

package stwl_pkg;

  localparam int LAP_W        = 24;
  localparam int IDX_W        = 5;
  localparam int COUNT_W      = 6;
  localparam int HOURS_W      = 8;
  localparam int MINUTES_W    = 6;
  localparam int SECONDS_W    = 6;
  localparam int TENTHS_W     = 4;
  localparam int MAX_LAPS_DEF = 32;

  localparam logic [LAP_W-1:0]     ELAPSED_LIMIT = 24'd9215999;
  localparam logic [LAP_W-1:0]     LAP_ONES      = '1;
  localparam logic [MINUTES_W-1:0] MINUTES_MAX   = 6'd59;
  localparam logic [SECONDS_W-1:0] SECONDS_MAX   = 6'd59;
  localparam logic [TENTHS_W-1:0]  TENTHS_MAX    = 4'd9;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_TOGGLE = 2'd1,
    OP_LAP    = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef struct packed {
    op_t              operation;
    logic [IDX_W-1:0] lap_index;
  } stwl_cmd_t;

  typedef struct packed {
    logic                 running;
    logic [HOURS_W-1:0]   elapsed_hours;
    logic [MINUTES_W-1:0] elapsed_minutes;
    logic [SECONDS_W-1:0] elapsed_seconds;
    logic [TENTHS_W-1:0]  elapsed_tenths;
    logic [COUNT_W-1:0]   lap_count;
    logic                 laps_full;
    logic [LAP_W-1:0]     lap_time;
    logic                 lap_is_longest;
    logic                 lap_is_shortest;
    logic [LAP_W-1:0]     longest_lap;
    logic [LAP_W-1:0]     shortest_lap;
  } stwl_res_t;

  typedef struct packed {
    logic [HOURS_W-1:0]   hours;
    logic [MINUTES_W-1:0] minutes;
    logic [SECONDS_W-1:0] seconds;
    logic [TENTHS_W-1:0]  tenths;
  } stwl_time_t;

  typedef struct packed {
    logic inc;
    logic clr;
  } stwl_time_ctl_t;

endpackage

`default_nettype wire

// File: hw/rtl/stopwatch_lap_timer_unit.sv
// Top level of the stopwatch lap timer: event decode, lap store and result assembly.
`default_nettype none

// Stopwatch with lap recording, counting in tenths of a second. Each item on
// command is one event (tick, start/stop, lap-or-clear, read lap) and yields
// exactly one result item. An item is taken at a rising edge with start high
// and busy low; its result appears on result, with done high, in the very
// next cycle and for that cycle only: there is no way to hold it, so capture
// it then. busy is high during that result cycle, so a new item is taken
// only once the last one's result is out. That is set by the lap store, a
// synchronous memory with a registered read: in the accept cycle all state
// is updated and the lap read issued; in the following cycle the result
// is assembled from the updated state and the read data.
// Elapsed time is kept twice: as a binary count in tenths (for lap splits)
// and as hours/minutes/seconds/tenths digits (for the display fields), so no
// division is needed. The count saturates at 255:59:59.9. The lap store has
// no reset and no clearing pass: a read at or beyond the stored lap count
// returns zero, and every entry below that count has been written since the
// last clear. Clear (lap button while stopped) takes effect at once.
module stopwatch_lap_timer_unit
  import stwl_pkg::*;
#(
  parameter int MAX_LAPS = MAX_LAPS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  input  wire stwl_cmd_t command,
  output logic           busy,
  output logic           done,
  output stwl_res_t      result
);

  localparam int CntW  = $clog2(MAX_LAPS + 1);
  localparam int AddrW = (MAX_LAPS > 1) ? $clog2(MAX_LAPS) : 1;
  localparam int CmpW  = (CntW > IDX_W) ? CntW : IDX_W;

  // Architectural state
  logic [LAP_W-1:0] elapsed_count, elapsed_count_next;
  logic [LAP_W-1:0] lap_mark, lap_mark_next;
  logic             running_flag, running_flag_next;
  logic [CntW-1:0]  stored_laps, stored_laps_next;
  logic [LAP_W-1:0] longest_value, longest_value_next;
  logic [LAP_W-1:0] shortest_value, shortest_value_next;

  // Lap store and its registered read port
  logic [LAP_W-1:0] lap_mem [MAX_LAPS];
  logic [LAP_W-1:0] rd_data;
  logic             mem_we;

  // Per-item values carried from the accept cycle to the result cycle
  logic [LAP_W-1:0] split, split_next;
  logic             show, show_next;
  logic             read_op, read_op_next;
  logic             read_hit, read_hit_next;

  logic             accept;
  logic [LAP_W-1:0] lap_calc;
  logic [LAP_W-1:0] lap_time;
  stwl_time_ctl_t   time_ctl;
  stwl_time_t       digits;

  assign accept   = start && !busy;
  assign busy     = done;
  assign lap_calc = elapsed_count - lap_mark;

  // Decode the event and work out the next state.
  always_comb begin
    elapsed_count_next  = elapsed_count;
    lap_mark_next       = lap_mark;
    running_flag_next   = running_flag;
    stored_laps_next    = stored_laps;
    longest_value_next  = longest_value;
    shortest_value_next = shortest_value;
    time_ctl            = '0;
    mem_we              = 1'b0;
    split_next          = '0;
    show_next           = 1'b0;
    read_op_next        = 1'b0;
    read_hit_next       = CmpW'(command.lap_index) < CmpW'(stored_laps);
    if (accept) begin
      unique case (command.operation)
        OP_TICK: begin
          // Count only while running; hold at the limit.
          if (running_flag && (elapsed_count != ELAPSED_LIMIT)) begin
            elapsed_count_next = elapsed_count + LAP_W'(1);
            time_ctl.inc       = 1'b1;
          end
        end
        OP_TOGGLE: begin
          running_flag_next = !running_flag;
        end
        OP_LAP: begin
          if (running_flag) begin
            // Record a split unless the store is full; ties keep the old extreme.
            if (stored_laps < CntW'(MAX_LAPS)) begin
              split_next       = lap_calc;
              lap_mark_next    = elapsed_count;
              mem_we           = 1'b1;
              stored_laps_next = stored_laps + CntW'(1);
              show_next        = 1'b1;
              if (lap_calc > longest_value) begin
                longest_value_next = lap_calc;
              end
              if (lap_calc < shortest_value) begin
                shortest_value_next = lap_calc;
              end
            end
          end else begin
            // Stopped: clear everything back to the reset picture.
            elapsed_count_next  = '0;
            lap_mark_next       = '0;
            stored_laps_next    = '0;
            longest_value_next  = '0;
            shortest_value_next = LAP_ONES;
            time_ctl.clr        = 1'b1;
          end
        end
        OP_READ: begin
          show_next    = 1'b1;
          read_op_next = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed_count  <= '0;
      lap_mark       <= '0;
      running_flag   <= 1'b0;
      stored_laps    <= '0;
      longest_value  <= '0;
      shortest_value <= LAP_ONES;
      done           <= 1'b0;
    end else begin
      elapsed_count  <= elapsed_count_next;
      lap_mark       <= lap_mark_next;
      running_flag   <= running_flag_next;
      stored_laps    <= stored_laps_next;
      longest_value  <= longest_value_next;
      shortest_value <= shortest_value_next;
      done           <= accept;
    end
  end

  // Per-item payload: load on accept only.
  always_ff @(posedge clk) begin
    if (accept) begin
      split    <= split_next;
      show     <= show_next;
      read_op  <= read_op_next;
      read_hit <= read_hit_next;
    end
  end

  // Lap store: write the new split at the fill position, read at the requested index.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      lap_mem[AddrW'(stored_laps)] <= lap_calc;
    end
    rd_data <= lap_mem[AddrW'(command.lap_index)];
  end

  stwl_time_count u_time (
    .clk    (clk),
    .rst    (rst),
    .ctl    (time_ctl),
    .digits (digits)
  );

  // Assemble the result from the updated state; drop unstored reads to zero.
  assign lap_time = read_op ? (read_hit ? rd_data : '0) : split;

  always_comb begin
    result.running         = running_flag;
    result.elapsed_hours   = digits.hours;
    result.elapsed_minutes = digits.minutes;
    result.elapsed_seconds = digits.seconds;
    result.elapsed_tenths  = digits.tenths;
    result.lap_count       = COUNT_W'(stored_laps);
    result.laps_full       = stored_laps >= CntW'(MAX_LAPS);
    result.lap_time        = lap_time;
    result.lap_is_longest  = show && (stored_laps > CntW'(1)) && (lap_time == longest_value);
    result.lap_is_shortest = show && (stored_laps > CntW'(1)) && (lap_time == shortest_value);
    result.longest_lap     = longest_value;
    result.shortest_lap    = shortest_value;
  end

endmodule

`default_nettype wire

// File: hw/rtl/stwl_time_count.sv
// Mixed-radix hours/minutes/seconds/tenths counter kept alongside the binary count.
`default_nettype none

module stwl_time_count
  import stwl_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire stwl_time_ctl_t ctl,
  output stwl_time_t          digits
);

  stwl_time_t cnt;
  stwl_time_t cnt_next;

  // Ripple the carry through tenths, seconds, minutes, hours.
  // Saturation is guarded by the caller, so hours never wrap.
  always_comb begin
    cnt_next = cnt;
    if (ctl.clr) begin
      cnt_next = '0;
    end else if (ctl.inc) begin
      if (cnt.tenths == TENTHS_MAX) begin
        cnt_next.tenths = '0;
        if (cnt.seconds == SECONDS_MAX) begin
          cnt_next.seconds = '0;
          if (cnt.minutes == MINUTES_MAX) begin
            cnt_next.minutes = '0;
            cnt_next.hours   = cnt.hours + HOURS_W'(1);
          end else begin
            cnt_next.minutes = cnt.minutes + MINUTES_W'(1);
          end
        end else begin
          cnt_next.seconds = cnt.seconds + SECONDS_W'(1);
        end
      end else begin
        cnt_next.tenths = cnt.tenths + TENTHS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  assign digits = cnt;

endmodule

`default_nettype wire

// File: hw/rtl/stwl_checker.sv
// Port-level checks for the stopwatch lap timer, bound to the top level.
`default_nettype none

module stwl_checker
  import stwl_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      start,
  input wire logic      busy,
  input wire logic      done,
  input wire stwl_res_t result
);

  // Every accepted item gives its result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> done)
    else $error("accepted item without a result in the next cycle");

  // One result per item: a strobe is never high back to back.
  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for two cycles");

  // A flagged longest lap matches the reported longest.
  a_longest_match: assert property (@(posedge clk) disable iff (rst)
    done && result.lap_is_longest |-> result.lap_time == result.longest_lap)
    else $error("longest flag without matching lap time");

  // With no laps stored the extremes sit at their cleared values.
  a_empty_extremes: assert property (@(posedge clk) disable iff (rst)
    done && (result.lap_count == '0) && !result.laps_full |->
      (result.longest_lap == '0) && (result.shortest_lap == LAP_ONES))
    else $error("extremes not cleared while no laps are stored");

endmodule

bind stopwatch_lap_timer_unit stwl_checker u_stwl_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .done    (done),
  .result  (result)
);

`default_nettype wire

// File: verif/tb_stopwatch_lap_timer_unit.sv
// Self-checking testbench of the stopwatch lap timer: event stimulus, prediction and checking.
`timescale 1ns / 1ps

module tb_stopwatch_lap_timer_unit;
  import stwl_pkg::*;

  localparam int LAP_SLOTS = MAX_LAPS_DEF;

  // Tracks the watch as the block should see it and holds the readouts that
  // each accepted event must produce, oldest first.
  class stopwatch_tracker;
    logic [LAP_W-1:0] count_tenths;
    logic [LAP_W-1:0] mark_tenths;
    logic [LAP_W-1:0] longest;
    logic [LAP_W-1:0] shortest;
    logic [LAP_W-1:0] lap_slots [LAP_SLOTS];
    bit               ticking;
    int unsigned      laps_held;
    stwl_res_t        due_readouts [$];
    int               mismatch_count;

    function new();
      mismatch_count = 0;
      wipe();
    endfunction

    // Clear everything, as the lap button does while stopped.
    function void wipe();
      count_tenths = '0;
      mark_tenths  = '0;
      longest      = '0;
      shortest     = LAP_ONES;
      ticking      = 1'b0;
      laps_held    = 0;
      foreach (lap_slots[i]) lap_slots[i] = '0;
    endfunction

    // Apply one accepted event and queue the readout it must produce.
    function void take_event(stwl_cmd_t cmd);
      logic [LAP_W-1:0] lap;
      bit               show;
      int unsigned      t;
      stwl_res_t        r;
      lap  = '0;
      show = 1'b0;
      case (cmd.operation)
        OP_TICK: begin
          if (ticking && count_tenths < ELAPSED_LIMIT) count_tenths++;
        end
        OP_TOGGLE: ticking = !ticking;
        OP_LAP: begin
          if (!ticking) begin
            wipe();
          end else if (laps_held < LAP_SLOTS) begin
            lap = count_tenths - mark_tenths;
            mark_tenths = count_tenths;
            lap_slots[laps_held] = lap;
            laps_held++;
            if (lap > longest) longest = lap;
            if (lap < shortest) shortest = lap;
            show = 1'b1;
          end
        end
        default: begin
          if (cmd.lap_index < laps_held) lap = lap_slots[cmd.lap_index];
          show = 1'b1;
        end
      endcase
      t = count_tenths;
      r.running         = ticking;
      r.elapsed_hours   = HOURS_W'(t / 36000);
      r.elapsed_minutes = MINUTES_W'((t % 36000) / 600);
      r.elapsed_seconds = SECONDS_W'((t % 600) / 10);
      r.elapsed_tenths  = TENTHS_W'(t % 10);
      r.lap_count       = COUNT_W'(laps_held);
      r.laps_full       = laps_held >= LAP_SLOTS;
      r.lap_time        = lap;
      r.lap_is_longest  = show && laps_held > 1 && lap == longest;
      r.lap_is_shortest = show && laps_held > 1 && lap == shortest;
      r.longest_lap     = longest;
      r.shortest_lap    = shortest;
      due_readouts.push_back(r);
    endfunction

    function void check_field(string name, logic [LAP_W-1:0] want, logic [LAP_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatch_count++;
      end
    endfunction

    // Compare one readout of the block with the oldest one due.
    function void compare_readout(stwl_res_t got);
      stwl_res_t want;
      if (due_readouts.size() == 0) begin
        $error("readout with no item outstanding");
        mismatch_count++;
        return;
      end
      want = due_readouts.pop_front();
      check_field("running", want.running, got.running);
      check_field("elapsed_hours", want.elapsed_hours, got.elapsed_hours);
      check_field("elapsed_minutes", want.elapsed_minutes, got.elapsed_minutes);
      check_field("elapsed_seconds", want.elapsed_seconds, got.elapsed_seconds);
      check_field("elapsed_tenths", want.elapsed_tenths, got.elapsed_tenths);
      check_field("lap_count", want.lap_count, got.lap_count);
      check_field("laps_full", want.laps_full, got.laps_full);
      check_field("lap_time", want.lap_time, got.lap_time);
      check_field("lap_is_longest", want.lap_is_longest, got.lap_is_longest);
      check_field("lap_is_shortest", want.lap_is_shortest, got.lap_is_shortest);
      check_field("longest_lap", want.longest_lap, got.longest_lap);
      check_field("shortest_lap", want.shortest_lap, got.shortest_lap);
    endfunction

    function int outstanding();
      return due_readouts.size();
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  stwl_cmd_t command = '0;
  logic      busy;
  logic      done;
  stwl_res_t result;

  stopwatch_tracker tracker = new();

  // Shadow of the watch as the stimulus sees it, so that reads only touch lap
  // entries that have been written at some point since reset.
  bit          sh_running = 1'b0;
  int unsigned sh_laps = 0;
  bit          sh_written [LAP_SLOTS];

  stopwatch_lap_timer_unit dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .busy    (busy),
    .done    (done),
    .result  (result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watch both sides at the clock edge: a readout is there for one cycle only,
  // and an item goes in where start is high and busy low.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) tracker.compare_readout(result);
      if (start && !busy) tracker.take_event(command);
    end
  end

  // Present one event, hold it until taken, then idle for a while at random.
  task automatic send_event(input op_t op, input logic [IDX_W-1:0] idx, input int idle_pct);
    stwl_cmd_t c;
    c.operation = op;
    c.lap_index = idx;
    command <= c;
    start   <= 1'b1;
    do @(posedge clk); while (!(start && !busy));
    // Advance the shadow the same way the watch moves.
    case (op)
      OP_TOGGLE: sh_running = !sh_running;
      OP_LAP: begin
        if (!sh_running) begin
          sh_laps = 0;
        end else if (sh_laps < LAP_SLOTS) begin
          sh_written[sh_laps] = 1'b1;
          sh_laps++;
        end
      end
      default: ;
    endcase
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // One random event, weighted by whether the watch runs. Stopped-state ticks
  // and stray reads make up the noise; reads beyond the lap count only hit
  // entries written before some clear.
  task automatic random_event(input int idle_pct, output bit effective);
    int               roll;
    op_t              op;
    logic [IDX_W-1:0] idx;
    roll = $urandom_range(99);
    idx  = IDX_W'($urandom_range(LAP_SLOTS - 1));
    if (sh_running) begin
      if (roll < 4) op = OP_TOGGLE;
      else if (roll < 30) op = OP_LAP;
      else if (roll < 75) op = OP_TICK;
      else op = OP_READ;
    end else begin
      if (roll < 45) op = OP_TOGGLE;
      else if (roll < 60) op = OP_LAP;
      else if (roll < 80) op = OP_TICK;
      else op = OP_READ;
    end
    if (op == OP_READ) begin
      if (sh_laps > 0 && $urandom_range(99) < 80) begin
        idx = IDX_W'($urandom_range(sh_laps - 1));
      end else if (idx >= sh_laps && !sh_written[idx]) begin
        if (sh_laps > 0) idx = IDX_W'($urandom_range(sh_laps - 1));
        else op = OP_TICK;
      end
    end
    effective = !(op == OP_TICK && !sh_running);
    send_event(op, idx, idle_pct);
  endtask

  task automatic random_run(input int count, input int idle_pct);
    int taken;
    bit eff;
    taken = 0;
    while (taken < count) begin
      random_event(idle_pct, eff);
      if (eff) taken++;
    end
  endtask

  // Clear, start, and lap until the store overflows, then read back a few.
  task automatic fill_store(input int idle_pct);
    if (sh_running) send_event(OP_TOGGLE, IDX_W'($urandom_range(31)), idle_pct);
    send_event(OP_LAP, IDX_W'($urandom_range(31)), idle_pct);
    send_event(OP_TOGGLE, IDX_W'($urandom_range(31)), idle_pct);
    repeat (LAP_SLOTS + 3) begin
      repeat ($urandom_range(0, 3)) send_event(OP_TICK, IDX_W'($urandom_range(31)), idle_pct);
      send_event(OP_LAP, IDX_W'($urandom_range(31)), idle_pct);
    end
    send_event(OP_READ, IDX_W'(LAP_SLOTS - 1), idle_pct);
    send_event(OP_READ, '0, idle_pct);
    repeat (6) send_event(OP_READ, IDX_W'($urandom_range(LAP_SLOTS - 1)), idle_pct);
  endtask

  // Short directed opening: stopped tick, clear at reset, laps with ties and a
  // zero lap, reads of held laps, clear, then reads past the lap count.
  task automatic directed_events(input int idle_pct);
    send_event(OP_TICK, 5'd31, idle_pct);
    send_event(OP_LAP, 5'd0, idle_pct);
    send_event(OP_TOGGLE, 5'd0, idle_pct);
    repeat (3) send_event(OP_TICK, 5'd0, idle_pct);
    send_event(OP_LAP, 5'd0, idle_pct);
    repeat (3) send_event(OP_TICK, 5'd0, idle_pct);
    send_event(OP_LAP, 5'd0, idle_pct);
    send_event(OP_LAP, 5'd0, idle_pct);
    send_event(OP_TICK, 5'd0, idle_pct);
    send_event(OP_LAP, 5'd0, idle_pct);
    send_event(OP_READ, 5'd1, idle_pct);
    send_event(OP_READ, 5'd2, idle_pct);
    send_event(OP_TOGGLE, 5'd0, idle_pct);
    send_event(OP_TICK, 5'd0, idle_pct);
    send_event(OP_READ, 5'd3, idle_pct);
    send_event(OP_LAP, 5'd0, idle_pct);
    send_event(OP_READ, 5'd2, idle_pct);
    send_event(OP_READ, 5'd0, idle_pct);
    send_event(OP_TOGGLE, 5'd0, idle_pct);
    send_event(OP_LAP, 5'd0, idle_pct);
  endtask

  initial begin
    int guard;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Sender idles about a third of the time.
    directed_events(34);
    fill_store(34);
    random_run(60, 34);

    // Sender idles most of the time.
    fill_store(87);
    random_run(40, 87);

    // Back to back: carry through seconds several times, then more random.
    if (!sh_running) send_event(OP_TOGGLE, IDX_W'($urandom_range(31)), 0);
    repeat (100) send_event(OP_TICK, IDX_W'($urandom_range(31)), 0);
    send_event(OP_LAP, IDX_W'($urandom_range(31)), 0);
    random_run(50, 0);

    start <= 1'b0;

    // Drain the readouts still due, then allow for the result cycle.
    guard = 0;
    while (tracker.outstanding() > 0 && guard < 200) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
    if (tracker.outstanding() > 0) begin
      $error("%0d readouts never arrived", tracker.outstanding());
      tracker.mismatch_count++;
    end
    if (tracker.mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Hang guard: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: stopwatch_lap_timer_unit.f
hw/rtl/stwl_pkg.sv
hw/rtl/stwl_time_count.sv
hw/rtl/stopwatch_lap_timer_unit.sv
hw/rtl/stwl_checker.sv
verif/tb_stopwatch_lap_timer_unit.sv
